FILE: rtl/ren_pkg.sv
// shared types and constants for the raft election node
package ren_pkg;

	localparam int MAX_NODES  = 16;
	localparam int TIMER_BITS = 16;
	localparam int TERM_W     = 31;
	localparam int TALLY_W    = $clog2(MAX_NODES + 1);
	localparam int LIMIT_W    = 16;
	localparam int CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [TERM_W-1:0] TERM_MAX  = {TERM_W{1'b1}};
	localparam logic [15:0]       LFSR_SEED = 16'hACE1;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_VOTE_REQ = 2'd1,
		OP_HEARTBT  = 2'd2,
		OP_VOTE_RSP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE      = 2'd0,
		ACT_VOTE_ANS  = 2'd1,
		ACT_BCAST_REQ = 2'd2,
		ACT_BCAST_HB  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ROLE_FOLLOWER  = 2'd0,
		ROLE_CANDIDATE = 2'd1,
		ROLE_LEADER    = 2'd2
	} role_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_ID      = 3'd0,
		REG_MEMBER_COUNT = 3'd1,
		REG_TIMEOUT_BASE = 3'd2,
		REG_SPREAD_MASK  = 3'd3,
		REG_HB_PERIOD    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [TERM_W-1:0] msg_term;
		logic [3:0]        sender_id;
		logic              granted;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        action;
		logic              vote_given;
		logic [TERM_W-1:0] current_term;
		logic [1:0]        role;
		logic              vote_valid;
		logic [3:0]        voted_node;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  node_id;
		logic [4:0]  member_count;
		logic [14:0] timeout_base;
		logic [14:0] timeout_spread_mask;
		logic [15:0] heartbeat_period;
	} cfg_t;

endpackage

FILE: rtl/ren_cfg.sv
// configuration register file for the raft election node
module ren_cfg
	import ren_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id             <= 4'd0;
			cfg_q.member_count        <= 5'd5;
			cfg_q.timeout_base        <= 15'd1500;
			cfg_q.timeout_spread_mask <= 15'd1023;
			cfg_q.heartbeat_period    <= 16'd600;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_NODE_ID:      cfg_q.node_id             <= wr_data[3:0];
				REG_MEMBER_COUNT: cfg_q.member_count        <= wr_data[4:0];
				REG_TIMEOUT_BASE: cfg_q.timeout_base        <= wr_data[14:0];
				REG_SPREAD_MASK:  cfg_q.timeout_spread_mask <= wr_data[14:0];
				REG_HB_PERIOD:    cfg_q.heartbeat_period    <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/ren_core.sv
// election state registers and the single-step update logic
module ren_core
	import ren_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	role_t               role_q, n_role;
	logic [TERM_W-1:0]   term_q, n_term;
	logic                voted_q, n_voted;
	logic [3:0]          target_q, n_target;
	logic [TIMER_BITS-1:0] elapsed_q, n_elapsed;
	logic [TALLY_W-1:0]  tally_q, n_tally;
	logic [15:0]         beat_q, n_beat;
	logic [15:0]         lfsr_q, n_lfsr;

	logic [TIMER_BITS-1:0] e_inc;
	logic [LIMIT_W-1:0]    limit;
	logic [15:0]           period;
	logic [16:0]           beat_inc;
	logic [TALLY_W-1:0]    half;
	logic                  newer, same;
	act_t                  act;
	logic                  given;

	always_comb begin
		n_role    = role_q;
		n_term    = term_q;
		n_voted   = voted_q;
		n_target  = target_q;
		n_elapsed = elapsed_q;
		n_tally   = tally_q;
		n_beat    = beat_q;
		n_lfsr    = lfsr_q;
		act       = ACT_NONE;
		given     = 1'b0;

		e_inc    = (elapsed_q != {TIMER_BITS{1'b1}}) ? elapsed_q + 1'b1 : elapsed_q;
		limit    = LIMIT_W'({1'b0, cfg.timeout_base})
		         + LIMIT_W'({1'b0, lfsr_q[14:0] & cfg.timeout_spread_mask});
		period   = (cfg.heartbeat_period == 16'd0) ? 16'd1 : cfg.heartbeat_period;
		beat_inc = {1'b0, beat_q} + 17'd1;
		half     = TALLY_W'(cfg.member_count >> 1);
		newer    = item.msg_term > term_q;
		same     = item.msg_term == term_q;

		case (op_t'(item.operation))
			OP_TICK: begin
				if (role_q != ROLE_LEADER) begin
					n_elapsed = e_inc;
					n_lfsr    = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
					if (CMP_W'(e_inc) > CMP_W'(limit)) begin
						n_role    = ROLE_CANDIDATE;
						n_term    = (term_q != TERM_MAX) ? term_q + 1'b1 : term_q;
						n_voted   = 1'b1;
						n_target  = cfg.node_id;
						n_elapsed = '0;
						n_tally   = TALLY_W'(1);
						act       = ACT_BCAST_REQ;
						if (TALLY_W'(1) > half) begin
							n_role = ROLE_LEADER;
							n_beat = 16'd0;
						end
					end
				end else begin
					if (beat_q == 16'd0)
						act = ACT_BCAST_HB;
					n_beat = (beat_inc >= {1'b0, period}) ? 16'd0 : beat_inc[15:0];
				end
			end
			OP_VOTE_REQ: begin
				act = ACT_VOTE_ANS;
				if (newer || same) begin
					if (newer) begin
						n_term   = item.msg_term;
						n_role   = ROLE_FOLLOWER;
						n_tally  = '0;
						n_voted  = 1'b0;
						n_target = 4'd0;
					end
					if (!n_voted || n_target == item.sender_id) begin
						n_voted   = 1'b1;
						n_target  = item.sender_id;
						n_elapsed = '0;
						given     = 1'b1;
					end
				end
			end
			OP_HEARTBT: begin
				if (newer || same) begin
					if (newer) begin
						n_term   = item.msg_term;
						n_voted  = 1'b0;
						n_target = 4'd0;
					end
					n_role    = ROLE_FOLLOWER;
					n_tally   = '0;
					n_elapsed = '0;
				end
			end
			OP_VOTE_RSP: begin
				if (newer) begin
					n_term   = item.msg_term;
					n_role   = ROLE_FOLLOWER;
					n_tally  = '0;
					n_voted  = 1'b0;
					n_target = 4'd0;
				end else if (same && role_q == ROLE_CANDIDATE && item.granted) begin
					if (tally_q < TALLY_W'(MAX_NODES))
						n_tally = tally_q + 1'b1;
					if (n_tally > half) begin
						n_role = ROLE_LEADER;
						n_beat = 16'd0;
					end
				end
			end
			default: ;
		endcase

		result.action       = act;
		result.vote_given   = given;
		result.current_term = n_term;
		result.role         = n_role;
		result.vote_valid   = n_voted;
		result.voted_node   = n_voted ? n_target : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q    <= ROLE_FOLLOWER;
			term_q    <= '0;
			voted_q   <= 1'b0;
			target_q  <= 4'd0;
			elapsed_q <= '0;
			tally_q   <= '0;
			beat_q    <= 16'd0;
			lfsr_q    <= LFSR_SEED;
		end else if (step_en) begin
			role_q    <= n_role;
			term_q    <= n_term;
			voted_q   <= n_voted;
			target_q  <= n_target;
			elapsed_q <= n_elapsed;
			tally_q   <= n_tally;
			beat_q    <= n_beat;
			lfsr_q    <= n_lfsr;
		end
	end

endmodule

FILE: rtl/raft_election_node_unit.sv
// raft election node top level: input register, step logic, result register
// One item per cycle is accepted while in_stall is low. The input register
// takes the item, the step logic updates the election state from it and the
// result register captures the result, which raises out_valid; a stall on the
// output can come between the two registers. The election state is updated in
// a single step. A stalled result holds the output register while one more item
// may wait in the input register. Configuration writes are always ready and take
// effect on the next cycle; write them only when the block is idle.
module raft_election_node_unit
	import ren_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;
	logic      out_free;
	logic      step_en;
	logic      in_take;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign step_en   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;

	ren_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ren_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
